// ----- hw/rtl/bst_pkg.sv -----
// shared types and constants for the beacon sweep tracker
`timescale 1ns / 1ps

package bst_pkg;

	localparam int unsigned XW     = 10;
	localparam int unsigned AW     = 8;
	localparam int unsigned CFG_IW = 3;
	localparam int unsigned CFG_DW = 10;

	typedef enum logic [CFG_IW-1:0] {
		REG_INVALID_LIMIT = 3'd0,
		REG_ANGLE_MIN     = 3'd1,
		REG_ANGLE_MAX     = 3'd2,
		REG_SWEEP_STEP    = 3'd3,
		REG_CENTER_X      = 3'd4,
		REG_CENTER_BAND   = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [XW-1:0] invalid_limit;
		logic [AW-1:0] angle_min;
		logic [AW-1:0] angle_max;
		logic [AW-1:0] sweep_step;
		logic [XW-1:0] center_x;
		logic [XW-1:0] center_band;
	} cfg_t;

	typedef struct packed {
		logic [AW-1:0] angle;
		logic          seen;
		logic          centered;
		logic          up;
	} track_res_t;

endpackage

// ----- hw/rtl/bst_cfg.sv -----
// configuration register bank
`timescale 1ns / 1ps

module bst_cfg
	import bst_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [CFG_IW-1:0] wr_index,
	input  logic [CFG_DW-1:0] wr_data,
	output cfg_t              cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.invalid_limit <= XW'(1023);
			cfg_q.angle_min     <= AW'(0);
			cfg_q.angle_max     <= AW'(180);
			cfg_q.sweep_step    <= AW'(5);
			cfg_q.center_x      <= XW'(512);
			cfg_q.center_band   <= XW'(50);
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_INVALID_LIMIT: cfg_q.invalid_limit <= wr_data[XW-1:0];
				REG_ANGLE_MIN:     cfg_q.angle_min     <= wr_data[AW-1:0];
				REG_ANGLE_MAX:     cfg_q.angle_max     <= wr_data[AW-1:0];
				REG_SWEEP_STEP:    cfg_q.sweep_step    <= wr_data[AW-1:0];
				REG_CENTER_X:      cfg_q.center_x      <= wr_data[XW-1:0];
				REG_CENTER_BAND:   cfg_q.center_band   <= wr_data[XW-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- hw/rtl/bst_track.sv -----
// next angle, direction and flags for one report
`timescale 1ns / 1ps

module bst_track
	import bst_pkg::*;
(
	input  cfg_t          cfg,
	input  logic [AW-1:0] angle,
	input  logic          dir_up,
	input  logic [XW-1:0] blob_x,
	output track_res_t    res
);

	logic          lost;
	logic [AW:0]   step9;
	logic [AW:0]   lo9;
	logic [AW:0]   hi9;
	logic          up_go;
	logic [AW:0]   a1;
	logic          dn_go;
	logic [AW:0]   a2;
	logic          centered;
	logic          right;
	logic [XW-1:0] diff;
	logic [7:0]    quarter;
	logic [15:0]   prod;
	logic [AW:0]   inc9;
	logic [AW:0]   a_trk;

	always_comb begin
		lost  = (blob_x >= cfg.invalid_limit) || (blob_x == '0);
		step9 = {1'b0, cfg.sweep_step};
		lo9   = {1'b0, cfg.angle_min};
		hi9   = {1'b0, cfg.angle_max};

		// sweep: upward test, then downward test on the updated values
		up_go = dir_up && (({1'b0, angle} + step9) < hi9);
		a1    = up_go ? ({1'b0, angle} + step9) : {1'b0, angle};
		dn_go = !up_go && (a1 > (lo9 + step9));
		a2    = dn_go ? (a1 - step9) : a1;

		// band test and tracking move
		centered = (({1'b0, blob_x} + {1'b0, cfg.center_band}) > {1'b0, cfg.center_x})
			&& ({1'b0, blob_x} < ({1'b0, cfg.center_x} + {1'b0, cfg.center_band}));
		right = blob_x > cfg.center_x;
		diff  = right ? (blob_x - cfg.center_x) : (cfg.center_x - blob_x);
		// divide by 20: quarter, then divide by 5 through 205/1024
		quarter = diff[XW-1:2];
		prod    = 16'(quarter) * 16'd205;
		inc9    = (AW+1)'(prod[15:10]);
		if (centered) begin
			a_trk = {1'b0, angle};
		end else if (right) begin
			a_trk = ({1'b0, angle} > (lo9 + inc9)) ? ({1'b0, angle} - inc9) : {1'b0, angle};
		end else begin
			a_trk = (({1'b0, angle} + inc9) < hi9) ? ({1'b0, angle} + inc9) : {1'b0, angle};
		end

		if (lost) begin
			res.angle    = a2[AW-1:0];
			res.seen     = 1'b0;
			res.centered = 1'b0;
			res.up       = !dn_go;
		end else begin
			res.angle    = a_trk[AW-1:0];
			res.seen     = 1'b1;
			res.centered = centered;
			res.up       = dir_up;
		end
	end

endmodule

// ----- hw/rtl/beacon_sweep_tracker_unit.sv -----
// top level of the beacon sweep tracker
//
// channel  direction  handshake          payload
// s_       in         s_tvalid/s_tready  tuser camera, tdata blob_x
// m_       out        m_tvalid/m_tready  tuser camera_out, tdata angle and flags
// cfg_     in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// one request per cycle while not stalled; input register, then result register
// the per-camera angle register is read and rewritten in the same cycle
// reset: angles 0, all directions up, registers at their defaults
// a stalled result holds its register; the input stage keeps one more request
`timescale 1ns / 1ps

module beacon_sweep_tracker_unit
	import bst_pkg::*;
#(
	parameter int NUM_CAMERAS = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [15:0]       s_tdata,   // blob_x[9:0], zero fill
	input  logic [0:0]        s_tuser,   // camera
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [15:0]       m_tdata,   // servo_angle[7:0], beacon_seen, beacon_centered,
	                                     // sweeping_up, zero fill
	output logic [0:0]        m_tuser,   // camera_out
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [CFG_DW-1:0] cfg_data
);

	localparam int IDX_W = (NUM_CAMERAS > 1) ? $clog2(NUM_CAMERAS) : 1;

	cfg_t          cfg;
	logic          valid_s1;
	logic          cam_s1;
	logic [XW-1:0] x_s1;
	logic          valid_s2;
	logic          cam_s2;
	track_res_t    res_s2;
	logic [AW-1:0] angle_q [NUM_CAMERAS];
	logic [NUM_CAMERAS-1:0] dir_q;

	logic             move_s1;
	logic             in_range;
	logic [IDX_W-1:0] idx;
	logic [AW-1:0]    cur_angle;
	logic             cur_up;
	track_res_t       trk;

	assign cfg_ready = 1'b1;

	bst_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign move_s1  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || move_s1;
	assign in_range = 32'(cam_s1) < 32'(NUM_CAMERAS);
	assign idx      = IDX_W'(cam_s1);

	always_comb begin
		cur_angle = '0;
		cur_up    = 1'b0;
		if (in_range) begin
			cur_angle = angle_q[idx];
			cur_up    = dir_q[idx];
		end
	end

	bst_track u_track (
		.cfg    (cfg),
		.angle  (cur_angle),
		.dir_up (cur_up),
		.blob_x (x_s1),
		.res    (trk)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cam_s1 <= s_tuser[0];
			x_s1   <= s_tdata[XW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (move_s1) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			cam_s2 <= cam_s1;
			res_s2 <= in_range ? trk : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CAMERAS; i++) begin
				angle_q[i] <= '0;
			end
			dir_q <= '1;
		end else if (move_s1 && in_range) begin
			angle_q[idx] <= trk.angle;
			dir_q[idx]   <= trk.up;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = cam_s2;
	assign m_tdata  = {5'b0, res_s2.up, res_s2.centered, res_s2.seen, res_s2.angle};

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !m_tready) |-> !move_s1)
		else $error("result register overwritten while stalled");

	a_centered_seen: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(res_s2.centered && !res_s2.seen))
		else $error("centered flag without a seen beacon");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && m_tready && !move_s1) |=> !valid_s2)
		else $error("result repeated after it was taken");

endmodule

// ----- test/bst_track_checker.sv -----
// checker for the beacon sweep tracker: watches all channels, predicts each result and compares
`timescale 1ns / 1ps

module bst_track_checker
	import bst_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [15:0]       s_tdata,   // blob_x[9:0], zero fill
	input  logic [0:0]        s_tuser,   // camera
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [15:0]       m_tdata,   // servo_angle[7:0], beacon_seen, beacon_centered,
	                                     // sweeping_up, zero fill
	input  logic [0:0]        m_tuser,   // camera_out
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [CFG_DW-1:0] cfg_data,
	output int                mismatches,
	output int                tracks_due,
	output int                tracks_checked,
	output int                lost_reports,
	output int                centered_reports
);

	localparam int TRACK_DIV = 20;
	localparam int NUM_CAMS  = 2;

	typedef struct packed {
		logic       cam;
		track_res_t res;
	} track_expect_t;

	cfg_t          cfg_now;
	logic [AW-1:0] angle_of [NUM_CAMS];
	logic          dir_up [NUM_CAMS];
	track_expect_t due_tracks [$];
	track_expect_t oldest;

	function automatic track_expect_t predict_track(input logic cam, input logic [XW-1:0] x);
		int            a;
		int            lo;
		int            hi;
		int            stp;
		int            cx;
		int            band;
		int            xi;
		int            inc;
		logic          up;
		track_expect_t r;
		xi   = int'(x);
		lo   = int'(cfg_now.angle_min);
		hi   = int'(cfg_now.angle_max);
		stp  = int'(cfg_now.sweep_step);
		cx   = int'(cfg_now.center_x);
		band = int'(cfg_now.center_band);
		a    = int'(angle_of[cam]);
		up   = dir_up[cam];
		r    = '0;
		r.cam = cam;
		if (xi >= int'(cfg_now.invalid_limit) || xi <= 0) begin
			// lost beacon: up test first, then down test
			if (up && a < hi - stp)
				a += stp;
			else if (up)
				up = 1'b0;
			if (!up && a > lo + stp)
				a -= stp;
			else if (!up)
				up = 1'b1;
		end else begin
			r.res.seen = 1'b1;
			if (xi > cx - band && xi < cx + band) begin
				r.res.centered = 1'b1;
			end else if (xi > cx) begin
				inc = (xi - cx) / TRACK_DIV;
				if (a > lo + inc)
					a -= inc;
			end else begin
				inc = (cx - xi) / TRACK_DIV;
				if (a < hi - inc)
					a += inc;
			end
		end
		angle_of[cam] = a[AW-1:0];
		dir_up[cam]   = up;
		r.res.angle   = a[AW-1:0];
		r.res.up      = up;
		return r;
	endfunction

	task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_now.invalid_limit = 10'd1023;
			cfg_now.angle_min     = 8'd0;
			cfg_now.angle_max     = 8'd180;
			cfg_now.sweep_step    = 8'd5;
			cfg_now.center_x      = 10'd512;
			cfg_now.center_band   = 10'd50;
			for (int i = 0; i < NUM_CAMS; i++) begin
				angle_of[i] = '0;
				dir_up[i]   = 1'b1;
			end
			due_tracks.delete();
			mismatches       = 0;
			tracks_checked   = 0;
			lost_reports     = 0;
			centered_reports = 0;
			tracks_due      <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (due_tracks.size() == 0) begin
					mismatches++;
					$display("%0t: result with nothing expected, actual camera %0d tdata %h",
						$time, m_tuser, m_tdata);
				end else begin
					oldest = due_tracks.pop_front();
					check_field("camera_out", 8'(oldest.cam), 8'(m_tuser[0]));
					check_field("servo_angle", oldest.res.angle, m_tdata[7:0]);
					check_field("beacon_seen", 8'(oldest.res.seen), 8'(m_tdata[8]));
					check_field("beacon_centered", 8'(oldest.res.centered), 8'(m_tdata[9]));
					check_field("sweeping_up", 8'(oldest.res.up), 8'(m_tdata[10]));
					tracks_checked++;
				end
			end
			if (s_tvalid && s_tready) begin
				oldest = predict_track(s_tuser[0], s_tdata[XW-1:0]);
				if (!oldest.res.seen)
					lost_reports++;
				if (oldest.res.centered)
					centered_reports++;
				due_tracks.push_back(oldest);
			end
			if (cfg_valid && cfg_ready) begin
				case (reg_idx_t'(cfg_index))
					REG_INVALID_LIMIT: cfg_now.invalid_limit = cfg_data[XW-1:0];
					REG_ANGLE_MIN:     cfg_now.angle_min     = cfg_data[AW-1:0];
					REG_ANGLE_MAX:     cfg_now.angle_max     = cfg_data[AW-1:0];
					REG_SWEEP_STEP:    cfg_now.sweep_step    = cfg_data[AW-1:0];
					REG_CENTER_X:      cfg_now.center_x      = cfg_data[XW-1:0];
					REG_CENTER_BAND:   cfg_now.center_band   = cfg_data[XW-1:0];
					default: ;
				endcase
			end
			tracks_due <= due_tracks.size();
		end
	end

endmodule

// ----- test/tb_top.sv -----
// top of the beacon sweep tracker testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_top;
	import bst_pkg::*;

	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int HOLD_OFF_CYCLES = 60;
	localparam int N_DIRECTED      = 22;
	localparam logic       DIR_CAM [N_DIRECTED] = '{
		1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1,
		1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1
	};
	localparam logic [9:0] DIR_X [N_DIRECTED] = '{
		10'd0, 10'd1023, 10'd1, 10'd1022, 10'd462, 10'd463, 10'd561, 10'd562,
		10'd512, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1,
		10'd0, 10'd1022, 10'd1023, 10'd341, 10'd682
	};

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [15:0]       s_tdata;
	logic [0:0]        s_tuser;
	logic              m_tvalid;
	logic              m_tready;
	logic [15:0]       m_tdata;
	logic [0:0]        m_tuser;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [CFG_IW-1:0] cfg_index;
	logic [CFG_DW-1:0] cfg_data;

	int mismatches;
	int tracks_due;
	int tracks_checked;
	int lost_reports;
	int centered_reports;
	int cur_limit;
	int cur_cx;
	int cur_band;
	int settings_used;
	int reports_sent;
	int idle_cycles;
	bit quiet_run;
	bit hold_tgl;
	bit hold_seen;

	beacon_sweep_tracker_unit #(.NUM_CAMERAS(2)) u_dut (.*);

	bst_track_checker u_chk (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic send_report(input logic cam, input logic [9:0] x);
		if (!quiet_run && $urandom_range(99) < 7) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cam;
		s_tdata  <= {6'd0, x};
		do @(posedge clk); while (!s_tready);
		reports_sent++;
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (tracks_due != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DW-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic program_regs(input int il, input int lo, input int hi, input int stp,
			input int cx, input int band);
		drain_results();
		// upper bits of 8-bit registers get noise, the block must drop them
		write_reg(REG_INVALID_LIMIT, 10'(il));
		write_reg(REG_ANGLE_MIN, {2'($urandom_range(3)), 8'(lo)});
		write_reg(REG_ANGLE_MAX, {2'($urandom_range(3)), 8'(hi)});
		write_reg(REG_SWEEP_STEP, {2'($urandom_range(3)), 8'(stp)});
		write_reg(REG_CENTER_X, 10'(cx));
		write_reg(REG_CENTER_BAND, 10'(band));
		cfg_valid <= 1'b0;
		cur_limit = il;
		cur_cx    = cx;
		cur_band  = band;
		settings_used++;
	endtask

	function automatic logic [9:0] lost_x();
		if ($urandom_range(1) == 0)
			return 10'd0;
		return 10'($urandom_range(1023, cur_limit));
	endfunction

	task automatic run_reports(input int n);
		int   k;
		int   mode;
		int   burst;
		int   x;
		logic cam;
		k = 0;
		while (k < n) begin
			cam  = 1'($urandom_range(1));
			mode = $urandom_range(99);
			if (mode < 8) begin
				// long lost run on one camera to reach the sweep bounds
				burst = $urandom_range(6, 20);
				repeat (burst) send_report(cam, lost_x());
				k += burst;
			end else begin
				if (mode < 30) begin
					x = lost_x();
				end else if (mode < 55) begin
					x = cur_cx + ($urandom_range(1) ? cur_band : -cur_band)
						+ $urandom_range(4) - 2;
					x = (x < 0) ? 0 : (x > 1023) ? 1023 : x;
				end else begin
					x = $urandom_range(1023);
				end
				send_report(cam, x[9:0]);
				k++;
			end
		end
	endtask

	task automatic random_setting();
		program_regs(($urandom_range(3) == 0) ? $urandom_range(1, 1023) : $urandom_range(600, 1023),
			$urandom_range(0, 100), $urandom_range(100, 255), $urandom_range(1, 40),
			$urandom_range(0, 1023), $urandom_range(0, 120));
	endtask

	// receiver side
	initial begin
		m_tready  = 1'b0;
		hold_seen = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_tgl != hold_seen) begin
				hold_seen = hold_tgl;
				m_tready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end
			m_tready <= quiet_run || ($urandom_range(99) >= 10);
		end
	end

	// watchdog
	initial begin
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t: no request moved for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tuser       = '0;
		cfg_valid     = 1'b0;
		cfg_index     = REG_INVALID_LIMIT;
		cfg_data      = '0;
		quiet_run     = 1'b0;
		hold_tgl      = 1'b0;
		cur_limit     = 1023;
		cur_cx        = 512;
		cur_band      = 50;
		settings_used = 1;
		reports_sent  = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset defaults: bounds, band edges, reversal at the top bound
		for (int i = 0; i < N_DIRECTED; i++)
			send_report(DIR_CAM[i], DIR_X[i]);

		// every coordinate lost, step as wide as the travel
		program_regs(1, 0, 255, 255, 0, 0);
		run_reports(100);
		// inverted bounds freeze the angle
		program_regs(1023, 255, 0, 1, 1023, 1023);
		run_reports(100);
		// zero limit, empty band
		program_regs(0, 0, 255, 1, 512, 0);
		run_reports(80);
		program_regs(1023, 0, 255, 1, 0, 1);
		run_reports(120);

		// receiver stalls while reports keep coming
		program_regs(800, 20, 160, 7, 400, 30);
		run_reports(20);
		hold_tgl <= ~hold_tgl;
		run_reports(120);

		random_setting();
		run_reports(70);
		drain_results();
		run_reports(70);

		random_setting();
		quiet_run = 1'b1;
		run_reports(140);
		quiet_run = 1'b0;

		random_setting();
		run_reports(140);
		random_setting();
		run_reports(140);

		drain_results();
		repeat (10) @(posedge clk);
		$display("covered %0d reports over %0d register settings: %0d lost, %0d centered",
			reports_sent, settings_used, lost_reports, centered_reports);
		$display("%0d results checked, %0d mismatches", tracks_checked, mismatches);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
